// ===== hdl/gda_pkg.sv =====
// Shared types, codes and calendar helper functions for the Gregorian date unit.
// No dependencies; every other file of the block but gda_if refers to this package by scoped name.
package gda_pkg;

  localparam int unsigned MAX_YEAR_DEF    = 9999;
  localparam int unsigned AMOUNT_BITS_DEF = 16;

  // Internal year width covers every legal maximum year plus one.
  localparam int unsigned YEAR_W = 17;
  localparam int unsigned REM_W  = 17;
  localparam int unsigned Q100_W = 10;

  typedef enum logic [1:0] {
    ACT_ADD_DAYS     = 2'd0,
    ACT_ADD_YEARS    = 2'd1,
    ACT_NEXT_WEEKDAY = 2'd2,
    ACT_NEXT_SUNDAY  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  localparam logic [2:0] WD_SAT = 3'd0;
  localparam logic [2:0] WD_SUN = 3'd1;
  localparam logic [2:0] WD_FRI = 3'd6;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_MAR = 4'd3;
  localparam logic [3:0] MON_DEC = 4'd12;

  // A classified request as it passes from the front end to the back end.
  typedef struct packed {
    logic        bad;
    logic [1:0]  action;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] amount;
  } job_t;

  // Year divided by 100 through a reciprocal multiply; exact for years below 102400.
  function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] y);
    logic [34:0] p;
    p = {18'b0, y} * 35'd167773;
    return p[33:24];
  endfunction

  function automatic logic [6:0] rem100(input logic [YEAR_W-1:0] y,
                                        input logic [Q100_W-1:0] q);
    logic [YEAR_W-1:0] r;
    r = y - ({7'b0, q} * 17'd100);
    return r[6:0];
  endfunction

  function automatic logic is_leap(input logic [6:0] yy, input logic [1:0] cent);
    return (yy == 7'd0) ? (cent == 2'd0) : (yy[1:0] == 2'd0);
  endfunction

  function automatic logic [4:0] days_in(input logic leap, input logic [3:0] m);
    logic [4:0] n;
    unique case (m)
      MON_FEB:                   n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] month_key(input logic [3:0] m);
    logic [2:0] k;
    unique case (m)
      4'd1:    k = 3'd1;
      4'd2:    k = 3'd4;
      4'd3:    k = 3'd4;
      4'd4:    k = 3'd0;
      4'd5:    k = 3'd2;
      4'd6:    k = 3'd5;
      4'd7:    k = 3'd0;
      4'd8:    k = 3'd3;
      4'd9:    k = 3'd6;
      4'd10:   k = 3'd1;
      4'd11:   k = 3'd4;
      4'd12:   k = 3'd6;
      default: k = 3'd1;
    endcase
    return k;
  endfunction

  // Remainder by seven of a nine-bit value, reciprocal multiply then correction-free subtract.
  function automatic logic [2:0] mod7(input logic [8:0] v);
    logic [17:0] p;
    logic [8:0]  q;
    logic [8:0]  r;
    p = {9'b0, v} * 18'd293;
    q = {2'b0, p[17:11]};
    r = v - 9'(q * 9'd7);
    return r[2:0];
  endfunction

  // Weekday with Saturday as zero, from the year split into century code and year of century.
  function automatic logic [2:0] weekday_of(input logic [6:0] yy, input logic [1:0] cent,
                                            input logic leap, input logic [3:0] m,
                                            input logic [4:0] d);
    logic [8:0] t;
    logic       jf;
    jf = leap && (m == MON_JAN || m == MON_FEB);
    t = {4'b0, yy[6:2]} + {4'b0, d} + {6'b0, month_key(m)} + {2'b0, yy} + 9'd6
        - {6'b0, cent, 1'b0} - {8'b0, jf};
    return mod7(t);
  endfunction

  // One plus the Sundays after January 1 up to the given day offset.
  function automatic logic [5:0] week_of(input logic [8:0] off, input logic [2:0] w1);
    logic [3:0]  first;
    logic [8:0]  v;
    logic [17:0] p;
    if (w1 == WD_SUN) begin
      first = 4'd7;
    end else if (w1 == WD_SAT) begin
      first = 4'd1;
    end else begin
      first = 4'd8 - {1'b0, w1};
    end
    v = off - {5'b0, first};
    p = {9'b0, v} * 18'd293;
    if (off < {5'b0, first}) begin
      return 6'd1;
    end
    return 6'(p[17:11]) + 6'd2;
  endfunction

endpackage

// ===== hdl/gda_if.sv =====
// Request channel interfaces of the Gregorian date unit: operand side and result side.
// Depends on nothing; payload widths are those of the port fields.
interface gda_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [13:0] year_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in;
  logic [15:0] amount;

  modport source (output valid, action, year_in, month_in, day_in, amount, input ready);
  modport sink   (input valid, action, year_in, month_in, day_in, amount, output ready);
endinterface

interface gda_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [2:0]  weekday;
  logic [5:0]  week_number;
  logic [1:0]  status;

  modport source (output valid, year_out, month_out, day_out, weekday, week_number, status,
                  input ready);
  modport sink   (input valid, year_out, month_out, day_out, weekday, week_number, status,
                  output ready);
endinterface

// ===== hdl/gda_front.sv =====
// Front end of the date unit: takes a request, checks the operand date and queues a job.
// Depends on gda_pkg and gda_if.
module gda_front #(
  parameter int unsigned MAX_YEAR    = gda_pkg::MAX_YEAR_DEF,
  parameter int unsigned AMOUNT_BITS = gda_pkg::AMOUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  gda_in_if.sink         in_req,
  output gda_pkg::job_t  job,
  output logic           job_valid,
  input  logic           job_ready
);

  localparam logic [15:0] AMT_MASK =
    (AMOUNT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << AMOUNT_BITS) - 32'd1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_CHK  = 3'b100
  } fstate_t;

  fstate_t                       state;
  logic [1:0]                    action;
  logic [13:0]                   year;
  logic [3:0]                    month;
  logic [4:0]                    day;
  logic [15:0]                   amount;
  logic [gda_pkg::Q100_W-1:0]    q100;

  logic [6:0] yy;
  logic       leap;
  logic       good;

  always_comb begin
    yy   = gda_pkg::rem100({3'b0, year}, q100);
    leap = gda_pkg::is_leap(yy, q100[1:0]);
    good = (year != 14'd0) && ({3'b0, year} <= 17'(MAX_YEAR)) &&
           (month >= gda_pkg::MON_JAN) && (month <= gda_pkg::MON_DEC) &&
           (day != 5'd0) && (day <= gda_pkg::days_in(leap, month));
  end

  assign in_req.ready = (state == F_IDLE);
  assign job_valid    = (state == F_CHK);
  assign job          = '{bad: !good, action: action, year: year, month: month,
                          day: day, amount: amount};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (in_req.valid) state <= F_DIV;
        F_DIV:  state <= F_CHK;
        F_CHK:  if (job_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_req.valid) begin
      action <= in_req.action;
      year   <= in_req.year_in;
      month  <= in_req.month_in;
      day    <= in_req.day_in;
      amount <= in_req.amount & AMT_MASK;
    end
    if (state == F_DIV) begin
      q100 <= gda_pkg::div100({3'b0, year});
    end
  end

endmodule

// ===== hdl/gda_fifo.sv =====
// Two-entry job queue between the front and back ends of the date unit.
// Depends on gda_pkg for the job type.
module gda_fifo (
  input  logic           clk,
  input  logic           rst,
  input  gda_pkg::job_t  push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output gda_pkg::job_t  pop_data,
  output logic           pop_valid,
  input  logic           pop_ready
);

  gda_pkg::job_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ===== hdl/gda_back.sv =====
// Back end of the date unit: sequencer that advances the date and forms weekday and week.
// Depends on gda_pkg and gda_if.
module gda_back #(
  parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  gda_pkg::job_t  job,
  input  logic           job_valid,
  output logic           job_ready,
  gda_out_if.source      out_req
);

  typedef enum logic [8:0] {
    B_IDLE  = 9'b000000001,
    B_YDIV  = 9'b000000010,
    B_YINFO = 9'b000000100,
    B_OFS   = 9'b000001000,
    B_WDAY  = 9'b000010000,
    B_YEAR  = 9'b000100000,
    B_MON   = 9'b001000000,
    B_WEEK  = 9'b010000000,
    B_OUT   = 9'b100000000
  } bstate_t;

  bstate_t                     state;
  logic [gda_pkg::YEAR_W-1:0]  y;
  logic [3:0]                  m;
  logic [4:0]                  d;
  logic [1:0]                  act;
  logic [15:0]                 amt;
  logic                        final_pass;
  logic [gda_pkg::Q100_W-1:0]  q100;
  logic [6:0]                  yy;
  logic [1:0]                  cent;
  logic [8:0]                  off;
  logic [gda_pkg::REM_W-1:0]   rem;
  logic [3:0]                  k;
  logic [2:0]                  w1;
  logic                        valid;
  logic [13:0]                 year_out;
  logic [3:0]                  month_out;
  logic [4:0]                  day_out;
  logic [2:0]                  weekday;
  logic [5:0]                  week_number;
  logic [1:0]                  status;

  logic [17:0] new_year;
  logic [17:0] y_inc;
  logic [6:0]  yy_div;
  logic        leap;
  logic        leap_div;
  logic [2:0]  wd_now;
  logic [3:0]  step;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  always_comb begin
    new_year = {4'b0, job.year} + {2'b0, job.amount};
    y_inc    = {1'b0, y} + 18'd1;
    yy_div   = gda_pkg::rem100(y, q100);
    leap_div = gda_pkg::is_leap(yy_div, q100[1:0]);
    leap     = gda_pkg::is_leap(yy, cent);
    wd_now   = gda_pkg::weekday_of(yy, cent, leap, m, d);
    ylen     = leap ? 9'd366 : 9'd365;
    mlen     = gda_pkg::days_in(leap, m);
    if (act == gda_pkg::ACT_NEXT_WEEKDAY) begin
      step = (wd_now == gda_pkg::WD_FRI) ? 4'd3 : (wd_now == gda_pkg::WD_SAT) ? 4'd2 : 4'd1;
    end else begin
      step = (wd_now == gda_pkg::WD_SUN) ? 4'd7 : 4'd8 - {1'b0, wd_now};
      if (wd_now == gda_pkg::WD_SAT) step = 4'd1;
    end
  end

  assign job_ready           = (state == B_IDLE);
  assign out_req.valid       = valid;
  assign out_req.year_out    = year_out;
  assign out_req.month_out   = month_out;
  assign out_req.day_out     = day_out;
  assign out_req.weekday     = weekday;
  assign out_req.week_number = week_number;
  assign out_req.status      = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      valid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            m           <= job.month;
            d           <= job.day;
            act         <= job.action;
            amt         <= job.amount;
            final_pass  <= (job.action == gda_pkg::ACT_ADD_YEARS);
            year_out    <= '0;
            month_out   <= '0;
            day_out     <= '0;
            weekday     <= '0;
            week_number <= '0;
            if (job.bad) begin
              y      <= {3'b0, job.year};
              status <= gda_pkg::ST_BAD_DATE;
              valid  <= 1'b1;
              state  <= B_OUT;
            end else if (job.action == gda_pkg::ACT_ADD_YEARS &&
                         new_year > 18'(MAX_YEAR)) begin
              y      <= {3'b0, job.year};
              status <= gda_pkg::ST_RANGE;
              valid  <= 1'b1;
              state  <= B_OUT;
            end else if (job.action == gda_pkg::ACT_ADD_YEARS) begin
              y     <= new_year[gda_pkg::YEAR_W-1:0];
              state <= B_YDIV;
            end else begin
              y     <= {3'b0, job.year};
              state <= B_YDIV;
            end
          end
        end
        B_YDIV: begin
          q100  <= gda_pkg::div100(y);
          state <= B_YINFO;
        end
        B_YINFO: begin
          yy   <= yy_div;
          cent <= q100[1:0];
          // A leap day carried into a common year lands on the first of March.
          if (act == gda_pkg::ACT_ADD_YEARS && m == gda_pkg::MON_FEB && d == 5'd29 &&
              !leap_div) begin
            m   <= gda_pkg::MON_MAR;
            d   <= 5'd1;
            off <= 9'd59;
          end else begin
            off <= {4'b0, d} - 9'd1;
          end
          k     <= gda_pkg::MON_JAN;
          state <= B_OFS;
        end
        B_OFS: begin
          if (k < m && !(act == gda_pkg::ACT_ADD_YEARS && m == gda_pkg::MON_MAR &&
                          d == 5'd1 && off == 9'd59 && !leap)) begin
            off <= off + {4'b0, gda_pkg::days_in(leap, k)};
            k   <= k + 4'd1;
          end else begin
            state <= B_WDAY;
          end
        end
        B_WDAY: begin
          weekday <= wd_now;
          w1      <= gda_pkg::weekday_of(yy, cent, leap, gda_pkg::MON_JAN, 5'd1);
          if (final_pass) begin
            state <= B_WEEK;
          end else begin
            rem   <= {8'b0, off} + ((act == gda_pkg::ACT_ADD_DAYS) ? {1'b0, amt}
                                                                  : {13'b0, step});
            state <= B_YEAR;
          end
        end
        B_YEAR: begin
          if (rem >= {8'b0, ylen}) begin
            rem <= rem - {8'b0, ylen};
            if (y_inc > 18'(MAX_YEAR)) begin
              status <= gda_pkg::ST_RANGE;
              year_out    <= '0;
              month_out   <= '0;
              day_out     <= '0;
              weekday     <= '0;
              week_number <= '0;
              valid       <= 1'b1;
              state       <= B_OUT;
            end else begin
              y <= y_inc[gda_pkg::YEAR_W-1:0];
              if (yy == 7'd99) begin
                yy   <= 7'd0;
                cent <= cent + 2'd1;
              end else begin
                yy <= yy + 7'd1;
              end
            end
          end else begin
            off   <= rem[8:0];
            m     <= gda_pkg::MON_JAN;
            state <= B_MON;
          end
        end
        B_MON: begin
          if (m < gda_pkg::MON_DEC && rem >= {12'b0, mlen}) begin
            rem <= rem - {12'b0, mlen};
            m   <= m + 4'd1;
          end else begin
            d          <= rem[4:0] + 5'd1;
            final_pass <= 1'b1;
            state      <= B_WDAY;
          end
        end
        B_WEEK: begin
          year_out    <= y[13:0];
          month_out   <= m;
          day_out     <= d;
          week_number <= gda_pkg::week_of(off, w1);
          status      <= gda_pkg::ST_OK;
          valid       <= 1'b1;
          state       <= B_OUT;
        end
        B_OUT: begin
          if (out_req.ready) begin
            valid <= 1'b0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ok_date: assert property (@(posedge clk) disable iff (rst)
    (valid && status == gda_pkg::ST_OK) |->
      (month_out >= gda_pkg::MON_JAN && month_out <= gda_pkg::MON_DEC && day_out != 5'd0))
    else $error("result date out of calendar range");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && status != gda_pkg::ST_OK) |->
      (year_out == 14'd0 && month_out == 4'd0 && day_out == 5'd0 &&
       weekday == 3'd0 && week_number == 6'd0))
    else $error("error result carries a non-zero date");
  a_ok_week: assert property (@(posedge clk) disable iff (rst)
    (valid && status == gda_pkg::ST_OK) |->
      (weekday <= gda_pkg::WD_FRI && week_number != 6'd0 && week_number <= 6'd54))
    else $error("weekday or week number out of range");
`endif

endmodule

// ===== hdl/gregorian_date_arithmetic.sv =====
// Gregorian date arithmetic unit. Each request brings a date, an action and an amount;
// the date is checked and then advanced by days or years, or to the next weekday or the
// next Sunday, and one result comes back with the new date, its weekday (Saturday is
// zero) and its week number, or a status of invalid date or year out of range. A request
// is accepted by the front end, which divides its year by a hundred and checks the date,
// and then waits in a two-entry queue. The back end is a sequencer that takes one job at
// a time: it splits the year, adds up the days of the months before the operand month,
// forms the weekday, then, unless years are added, steps the date forward year by year
// and month by month, forms the weekday and week number of the result and hands it over;
// the year-by-year advance dominates for large day counts. The front end keeps taking
// requests while the back end works, until the queue is full.
// Depends on gda_pkg, gda_if, gda_front, gda_fifo and gda_back.
module gregorian_date_arithmetic #(
  parameter int unsigned MAX_YEAR    = gda_pkg::MAX_YEAR_DEF,
  parameter int unsigned AMOUNT_BITS = gda_pkg::AMOUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gda_in_if.sink     in_req,
  gda_out_if.source  out_req
);

  // Classified jobs on their way from the front end into the queue and out of it.
  gda_pkg::job_t push_job;
  logic          push_valid;
  logic          push_ready;
  gda_pkg::job_t pop_job;
  logic          pop_valid;
  logic          pop_ready;

  gda_front #(
    .MAX_YEAR    (MAX_YEAR),
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_req    (in_req),
    .job       (push_job),
    .job_valid (push_valid),
    .job_ready (push_ready)
  );

  gda_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // The back end owns the result register and holds it until the request is taken.
  gda_back #(
    .MAX_YEAR (MAX_YEAR)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (pop_job),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .out_req   (out_req)
  );

endmodule
